FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by stack_pattern_removal.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define SPR_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define SPR_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the stack pattern removal block.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

  localparam int BYTE_W    = 8;
  localparam int RIDX_W    = 12;
  localparam int DEPTH_W   = 13;
  localparam int LEN_W     = 5;
  localparam int PIDX_W    = 4;
  localparam int PAT_BYTES = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd2;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] byte_in;
    logic [RIDX_W-1:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               removed;
    logic [BYTE_W-1:0]  read_byte;
    logic               read_valid;
    logic               overflow;
  } out_word_t;

  // status from the pattern compare unit
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             hit;
  } pat_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_FETCH,
    ST_CMP,
    ST_RD,
    ST_RWAIT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: design/stack_pattern_removal.sv
// ----------------------------------------------------------------------------
// stack_pattern_removal
// Byte stack that pops a configured pattern as soon as it forms on top.
// ----------------------------------------------------------------------------
//  channel  ports                         direction  word
//  in       in_valid/in_ready/in_word     sink       op, byte_in, read_index
//  out      out_valid/out_ready/out_word  source     depth, flags, read_byte
//  cfg      cfg_we/cfg_index/cfg_wdata    sink       pattern registers
//
//  A push writes its byte and, when the pattern check runs (len =
//  effective pattern length), fetches and compares, ending early on a mismatch;
//  the single compare unit walks the top len stack bytes, one RAM read a cycle.
//  A push that needs no check skips the compare, a dropped push writes nothing,
//  and a read skips the RAM fetch when the index is at or above depth.
//  Reset (synchronous, active low) clears depth and the sequencer; the RAM is
//  never cleared, as only written entries below depth are ever read.
//  A result waits in the output register while out_ready is low; the next
//  word is accepted meanwhile and only its final handoff stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stack_pattern_removal #(
  parameter int STACK_DEPTH = 4096,
  parameter int PATTERN_MAX = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire spr_pkg::in_word_t              in_word,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      spr_pkg::out_word_t             out_word,
  input  wire logic                           cfg_we,
  input  wire logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [spr_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int TW = $clog2(STACK_DEPTH + 1);
  localparam int CW = (TW > spr_pkg::RIDX_W) ? TW : spr_pkg::RIDX_W;
  localparam logic [TW-1:0] TopFull = TW'(STACK_DEPTH);

  spr_pkg::state_t    state_r, state_nxt;
  spr_pkg::in_word_t  in_r, in_nxt;
  spr_pkg::out_word_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TW-1:0]      top_r, top_nxt;
  logic [TW-1:0]      base_r, base_nxt;
  logic [spr_pkg::PIDX_W-1:0] idx_r, idx_nxt;
  logic               removed_r, removed_nxt;
  logic               overflow_r, overflow_nxt;
  logic               rvalid_r, rvalid_nxt;
  logic [spr_pkg::BYTE_W-1:0] rbyte_r, rbyte_nxt;

  spr_pkg::pat_stat_t pat;
  logic                       mem_we;
  logic [AW-1:0]              mem_raddr;
  logic [spr_pkg::BYTE_W-1:0] mem_rdata;

  logic [TW-1:0]       top_inc;
  logic                top_full;
  logic                no_check;
  logic                last_byte;
  logic                rd_in_range;
  logic                out_free;
  logic [spr_pkg::LEN_W-1:0] idx_sel;
  logic [TW-1:0]       cmp_addr;
  logic [CW-1:0]       ridx_ext;

  // --------------------------------------------------------------------------
  // Shared parts: stack RAM and pattern compare unit
  // --------------------------------------------------------------------------
  spr_mem #(
    .DEPTH (STACK_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (top_r[AW-1:0]),
    .wdata (in_r.byte_in),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  spr_pattern #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_pattern (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .idx       (idx_r),
    .rdata     (mem_rdata),
    .stat      (pat)
  );

  // --------------------------------------------------------------------------
  // Decisions
  // --------------------------------------------------------------------------
  assign top_inc     = top_r + TW'(1);
  assign top_full    = (top_r == TopFull);
  // skip the check when the length is zero or the stack is too shallow
  assign no_check    = (pat.len == '0) || (top_inc < TW'(pat.len));
  assign last_byte   = ((spr_pkg::LEN_W'(idx_r) + spr_pkg::LEN_W'(1)) == pat.len);
  assign ridx_ext    = CW'(in_r.read_index);
  // depth never exceeds the store, so below depth is also inside it
  assign rd_in_range = (ridx_ext < CW'(top_r));
  assign out_free    = !out_valid_r || out_ready;

  // In FETCH address the first byte; in CMP look one byte ahead of the
  // byte being compared, as the RAM returns read data in the next cycle.
  assign idx_sel  = spr_pkg::LEN_W'(idx_r) +
                    ((state_r == spr_pkg::ST_CMP) ? spr_pkg::LEN_W'(1) : '0);
  assign cmp_addr = base_r + TW'(idx_sel);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spr_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_word.op == spr_pkg::OP_READ) begin
            state_nxt = spr_pkg::ST_RD;
          end else if (top_full) begin
            state_nxt = spr_pkg::ST_DONE;
          end else begin
            state_nxt = spr_pkg::ST_WRITE;
          end
        end
      end
      spr_pkg::ST_WRITE: begin
        state_nxt = no_check ? spr_pkg::ST_DONE : spr_pkg::ST_FETCH;
      end
      spr_pkg::ST_FETCH: begin
        state_nxt = spr_pkg::ST_CMP;
      end
      spr_pkg::ST_CMP: begin
        if (!pat.hit || last_byte) begin
          state_nxt = spr_pkg::ST_DONE;
        end
      end
      spr_pkg::ST_RD: begin
        state_nxt = rd_in_range ? spr_pkg::ST_RWAIT : spr_pkg::ST_DONE;
      end
      spr_pkg::ST_RWAIT: begin
        state_nxt = spr_pkg::ST_DONE;
      end
      spr_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = spr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spr_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs and datapath
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_raddr     = cmp_addr[AW-1:0];
    in_nxt        = in_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    top_nxt       = top_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    removed_nxt   = removed_r;
    overflow_nxt  = overflow_r;
    rvalid_nxt    = rvalid_r;
    rbyte_nxt     = rbyte_r;
    case (state_r)
      spr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // latch the word, clear the flags of the last step, flag overflow on a full push
          in_nxt       = in_word;
          removed_nxt  = 1'b0;
          rvalid_nxt   = 1'b0;
          rbyte_nxt    = '0;
          overflow_nxt = (in_word.op == spr_pkg::OP_PUSH) && top_full;
        end
      end
      spr_pkg::ST_WRITE: begin
        // push the byte, then set up the window of the top len entries
        mem_we   = 1'b1;
        top_nxt  = top_inc;
        base_nxt = top_inc - TW'(pat.len);
        idx_nxt  = '0;
      end
      spr_pkg::ST_FETCH: begin
        mem_raddr = cmp_addr[AW-1:0];
      end
      spr_pkg::ST_CMP: begin
        mem_raddr = cmp_addr[AW-1:0];
        if (pat.hit && last_byte) begin
          // drop the whole pattern at once
          top_nxt     = base_r;
          removed_nxt = 1'b1;
        end else if (pat.hit) begin
          idx_nxt = idx_r + spr_pkg::PIDX_W'(1);
        end
      end
      spr_pkg::ST_RD: begin
        mem_raddr = ridx_ext[AW-1:0];
      end
      spr_pkg::ST_RWAIT: begin
        rvalid_nxt = 1'b1;
        rbyte_nxt  = mem_rdata;
      end
      spr_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.depth      = spr_pkg::DEPTH_W'(top_r);
          out_nxt.removed    = removed_r;
          out_nxt.read_byte  = rbyte_r;
          out_nxt.read_valid = rvalid_r;
          out_nxt.overflow   = overflow_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      top_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      top_r       <= top_nxt;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    out_r      <= out_nxt;
    base_r     <= base_nxt;
    idx_r      <= idx_nxt;
    removed_r  <= removed_nxt;
    overflow_r <= overflow_nxt;
    rvalid_r   <= rvalid_nxt;
    rbyte_r    <= rbyte_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SPR_ASSERT_IMP(a_top_bound, clk, rst_n, 1'b1, top_r <= TopFull, "depth beyond store")
  `SPR_ASSERT_NXT(a_one_word, clk, rst_n, in_valid && in_ready, !in_ready, "second word taken early")
  `SPR_ASSERT_IMP(a_cmp_window, clk, rst_n, state_r == spr_pkg::ST_CMP, spr_pkg::LEN_W'(idx_r) < pat.len, "compare index past pattern")
  `SPR_ASSERT_IMP(a_flag_mix, clk, rst_n, out_valid_r && out_r.removed, !out_r.read_valid && !out_r.overflow, "removal mixed with other flags")

endmodule

`default_nettype wire

FILE: design/spr_mem.sv
// ----------------------------------------------------------------------------
// spr_mem
// Stack byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_mem #(
  parameter int DEPTH = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(DEPTH)-1:0]      waddr,
  input  wire logic [spr_pkg::BYTE_W-1:0]    wdata,
  input  wire logic [$clog2(DEPTH)-1:0]      raddr,
  output      logic [spr_pkg::BYTE_W-1:0]    rdata
);

  logic [spr_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/spr_pattern.sv
// ----------------------------------------------------------------------------
// spr_pattern
// Pattern registers and the shared byte compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_pattern #(
  parameter int PATTERN_MAX = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [spr_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire logic [spr_pkg::PIDX_W-1:0]     idx,
  input  wire logic [spr_pkg::BYTE_W-1:0]     rdata,
  output      spr_pkg::pat_stat_t             stat
);

  localparam logic [spr_pkg::LEN_W-1:0] LenMax = spr_pkg::LEN_W'(PATTERN_MAX);

  logic [spr_pkg::LEN_W-1:0] len_r;
  logic [spr_pkg::CFG_W-1:0] low_r;
  logic [spr_pkg::CFG_W-1:0] high_r;
  logic [spr_pkg::PAT_BYTES-1:0][spr_pkg::BYTE_W-1:0] pat_bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= spr_pkg::LEN_W'(1);
      low_r  <= '0;
      high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spr_pkg::CFG_PAT_LEN:  len_r  <= cfg_wdata[spr_pkg::LEN_W-1:0];
        spr_pkg::CFG_PAT_LOW:  low_r  <= cfg_wdata;
        spr_pkg::CFG_PAT_HIGH: high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pat_bytes = {high_r, low_r};

  // clamp long lengths, compare one stack byte against pattern byte idx
  assign stat.len = (len_r > LenMax) ? LenMax : len_r;
  assign stat.hit = (rdata == pat_bytes[idx]);

endmodule

`default_nettype wire
